@@ sv/rbvf_pkg.sv @@
// Shared types and constants of the border voxel filter.
`timescale 1ns / 1ps

package rbvf_pkg;

  localparam int unsigned LABEL_W   = 4;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned NB_N      = 6;
  localparam int unsigned STEP_W    = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_DIM_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Z = 2'd2;

  localparam logic [CFG_W-1:0] DIM_RESET = 7'd64;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [LABEL_W-1:0] LABEL_NONE   = 4'd0;
  localparam logic [LABEL_W-1:0] LABEL_CSF    = 4'd1;
  localparam logic [LABEL_W-1:0] LABEL_WM     = 4'd2;
  localparam logic [LABEL_W-1:0] LABEL_RIBBON = 4'd3;

  // Neighbor slots, in the order the back end reads them after the center.
  localparam int unsigned NB_XM = 0;
  localparam int unsigned NB_XP = 1;
  localparam int unsigned NB_YM = 2;
  localparam int unsigned NB_YP = 3;
  localparam int unsigned NB_ZM = 4;
  localparam int unsigned NB_ZP = 5;

  localparam logic [STEP_W-1:0] STEP_CENTER = 3'd0;
  localparam logic [STEP_W-1:0] STEP_LAST   = 3'd6;

  typedef struct packed {
    logic               func;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [POS_W-1:0]   pos_z;
    logic [LABEL_W-1:0] label_in;
  } in_req_t;

  typedef struct packed {
    logic [LABEL_W-1:0] label_out;
    logic               removed;
  } out_rsp_t;

  typedef struct packed {
    logic               func;
    logic               in_bounds;
    logic [NB_N-1:0]    nb_ok;
    logic [POS_W-1:0]   pos_x;
    logic [LABEL_W-1:0] label;
  } cmd_t;

endpackage

@@ sv/rbvf_front.sv @@
// Front end: clips the dimensions, classifies a request and forms its row index.
`timescale 1ns / 1ps

module rbvf_front #(
  parameter int unsigned MaxDimX = 64,
  parameter int unsigned MaxDimY = 64,
  parameter int unsigned MaxDimZ = 64,
  parameter int unsigned ZyW     = 12
) (
  input  logic [rbvf_pkg::CFG_W-1:0] dim_x_i,
  input  logic [rbvf_pkg::CFG_W-1:0] dim_y_i,
  input  logic [rbvf_pkg::CFG_W-1:0] dim_z_i,
  input  rbvf_pkg::in_req_t          req_i,
  output rbvf_pkg::cmd_t             cmd_o,
  output logic [ZyW-1:0]             zy_o
);
  import rbvf_pkg::*;

  function automatic logic [CFG_W-1:0] eff_dim(logic [CFG_W-1:0] v, int unsigned maxv);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (32'(v) > maxv) begin
      r = CFG_W'(maxv);
    end
    return r;
  endfunction

  logic [CFG_W-1:0] nx, ny, nz;
  logic [CFG_W-1:0] px, py, pz;

  always_comb begin
    nx = eff_dim(dim_x_i, MaxDimX);
    ny = eff_dim(dim_y_i, MaxDimY);
    nz = eff_dim(dim_z_i, MaxDimZ);
    px = CFG_W'(req_i.pos_x);
    py = CFG_W'(req_i.pos_y);
    pz = CFG_W'(req_i.pos_z);

    cmd_o.func         = req_i.func;
    cmd_o.in_bounds    = (px < nx) && (py < ny) && (pz < nz);
    cmd_o.nb_ok[NB_XM] = (px != '0);
    cmd_o.nb_ok[NB_XP] = ((px + CFG_W'(1)) < nx);
    cmd_o.nb_ok[NB_YM] = (py != '0);
    cmd_o.nb_ok[NB_YP] = ((py + CFG_W'(1)) < ny);
    cmd_o.nb_ok[NB_ZM] = (pz != '0);
    cmd_o.nb_ok[NB_ZP] = ((pz + CFG_W'(1)) < nz);
    cmd_o.pos_x        = req_i.pos_x;
    cmd_o.label        = req_i.label_in;

    zy_o = ZyW'(req_i.pos_z) * ZyW'(MaxDimY) + ZyW'(req_i.pos_y);
  end

endmodule

@@ sv/rbvf_queue.sv @@
// Two-entry queue of classified requests between the front and back ends.
`timescale 1ns / 1ps

module rbvf_queue #(
  parameter int unsigned ZyW = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rbvf_pkg::cmd_t       cmd_i,
  input  logic [ZyW-1:0]       zy_i,
  input  logic                 pop_i,
  output rbvf_pkg::cmd_t       cmd_o,
  output logic [ZyW-1:0]       zy_o,
  output logic                 full_o,
  output logic                 empty_o
);
  import rbvf_pkg::*;

  cmd_t           cmd_mem_q [2];
  logic [ZyW-1:0] zy_mem_q  [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;

  always_comb begin
    full_o   = (cnt_q == 2'd2);
    empty_o  = (cnt_q == 2'd0);
    cmd_o    = cmd_mem_q[rd_ptr_q];
    zy_o     = zy_mem_q[rd_ptr_q];
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      cmd_mem_q[wr_ptr_q] <= cmd_i;
      zy_mem_q[wr_ptr_q]  <= zy_i;
    end
  end

endmodule

@@ sv/rbvf_back.sv @@
// Back end: owns the label memory, performs writes and sequences query reads.
`timescale 1ns / 1ps

module rbvf_back #(
  parameter int unsigned MaxDimX = 64,
  parameter int unsigned MaxDimY = 64,
  parameter int unsigned MaxDimZ = 64,
  parameter int unsigned ZyW     = 12,
  parameter int unsigned AddrW   = 18
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rbvf_pkg::cmd_t      cmd_i,
  input  logic [ZyW-1:0]      zy_i,
  input  logic                empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rbvf_pkg::out_rsp_t  out_rsp_o
);
  import rbvf_pkg::*;

  localparam int unsigned Depth = MaxDimX * MaxDimY * MaxDimZ;
  localparam logic [AddrW-1:0] StrideX = AddrW'(1);
  localparam logic [AddrW-1:0] StrideY = AddrW'(MaxDimX);
  localparam logic [AddrW-1:0] StrideZ = AddrW'(MaxDimX * MaxDimY);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WRITE = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [LABEL_W-1:0] mem_q [Depth];
  logic [LABEL_W-1:0] rd_data_q;

  logic [1:0]         state_q, state_d;
  cmd_t               cmd_q, cmd_d;
  logic [AddrW-1:0]   base_q, base_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [STEP_W-1:0]  rd_step_q, rd_step_d;
  logic               rd_vld_q, rd_vld_d;
  logic [LABEL_W-1:0] center_q, center_d;
  logic               ribbon_q, ribbon_d;
  logic               out_valid_q, out_valid_d;
  out_rsp_t           out_rsp_q, out_rsp_d;

  logic               mem_we, mem_re;
  logic [AddrW-1:0]   mem_addr;
  logic               hit_now;
  logic               ribbon_now;
  logic               out_free;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    base_d      = base_q;
    step_d      = step_q;
    rd_step_d   = step_q;
    rd_vld_d    = 1'b0;
    center_d    = center_q;
    ribbon_d    = ribbon_q;
    out_valid_d = out_valid_q;
    out_rsp_d   = out_rsp_q;
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = base_q;
    hit_now     = 1'b0;
    out_free    = !out_valid_q || out_ready_i;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (rd_vld_q) begin
      if (rd_step_q == STEP_CENTER) begin
        center_d = rd_data_q;
      end else begin
        hit_now = cmd_q.nb_ok[rd_step_q - STEP_W'(1)] && (rd_data_q == LABEL_RIBBON);
      end
    end
    ribbon_now = ribbon_q || hit_now;
    ribbon_d   = ribbon_now;

    case (step_q)
      3'd1:    mem_addr = cmd_q.nb_ok[NB_XM] ? base_q - StrideX : base_q;
      3'd2:    mem_addr = cmd_q.nb_ok[NB_XP] ? base_q + StrideX : base_q;
      3'd3:    mem_addr = cmd_q.nb_ok[NB_YM] ? base_q - StrideY : base_q;
      3'd4:    mem_addr = cmd_q.nb_ok[NB_YP] ? base_q + StrideY : base_q;
      3'd5:    mem_addr = cmd_q.nb_ok[NB_ZM] ? base_q - StrideZ : base_q;
      3'd6:    mem_addr = cmd_q.nb_ok[NB_ZP] ? base_q + StrideZ : base_q;
      default: mem_addr = base_q;
    endcase

    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o    = 1'b1;
          cmd_d    = cmd_i;
          base_d   = AddrW'(zy_i) * AddrW'(MaxDimX) + AddrW'(cmd_i.pos_x);
          step_d   = STEP_CENTER;
          ribbon_d = 1'b0;
          center_d = LABEL_NONE;
          if (cmd_i.func == FUNC_WRITE) begin
            state_d = cmd_i.in_bounds ? ST_WRITE : ST_IDLE;
          end else begin
            state_d = cmd_i.in_bounds ? ST_READ : ST_FIN;
          end
        end
      end
      ST_WRITE: begin
        mem_we   = 1'b1;
        mem_addr = base_q;
        state_d  = ST_IDLE;
      end
      ST_READ: begin
        mem_re   = 1'b1;
        rd_vld_d = 1'b1;
        step_d   = step_q + STEP_W'(1);
        if (step_q == STEP_LAST) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_rsp_d.label_out = LABEL_NONE;
          out_rsp_d.removed   = 1'b0;
          if (cmd_q.in_bounds) begin
            out_rsp_d.label_out = center_q;
            if ((center_q inside {LABEL_CSF, LABEL_WM}) && !ribbon_now) begin
              out_rsp_d.label_out = LABEL_NONE;
              out_rsp_d.removed   = 1'b1;
            end
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_valid_o = out_valid_q;
    out_rsp_o   = out_rsp_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      step_q      <= STEP_CENTER;
    end else begin
      state_q     <= state_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    base_q    <= base_d;
    rd_step_q <= rd_step_d;
    center_q  <= center_d;
    ribbon_q  <= ribbon_d;
    out_rsp_q <= out_rsp_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= cmd_q.label;
    end else if (mem_re) begin
      rd_data_q <= mem_q[mem_addr];
    end
  end

endmodule

@@ sv/rim_border_voxel_filter.sv @@
// Top level of the border voxel filter: configuration registers and block wiring.
//
//   Port group   Direction   Handshake               Payload
//   in           request     in_valid_i/in_ready_o   in_req_i (in_req_t)
//   out          response    out_valid_o/out_ready_i out_rsp_o (out_rsp_t)
//   cfg          write       cfg_we_i                cfg_idx_i, cfg_data_i
//
// A query is popped and its memory address formed, then come seven single-port
// memory reads (the voxel and its six neighbors) and the response; one outside
// the volume skips the reads. A write is popped, then stored unless out of bounds.
// Reset clears the control state and sets all dimensions to 64; memory contents
// are not cleared. A stalled response holds the back end, and the two-entry
// queue keeps accepting requests until it fills.
`timescale 1ns / 1ps

module rim_border_voxel_filter #(
  parameter int unsigned MAX_DIM_X = 64,
  parameter int unsigned MAX_DIM_Y = 64,
  parameter int unsigned MAX_DIM_Z = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rbvf_pkg::in_req_t             in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rbvf_pkg::out_rsp_t            out_rsp_o,
  input  logic                          cfg_we_i,
  input  logic [rbvf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rbvf_pkg::CFG_W-1:0]     cfg_data_i
);
  import rbvf_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_DIM_X * MAX_DIM_Y * MAX_DIM_Z);
  localparam int unsigned ZyW   = $clog2(MAX_DIM_Y * MAX_DIM_Z);

  logic [CFG_W-1:0] dim_x_q, dim_y_q, dim_z_q;

  cmd_t           front_cmd, head_cmd;
  logic [ZyW-1:0] front_zy, head_zy;
  logic           q_full, q_empty, q_push, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_x_q <= DIM_RESET;
      dim_y_q <= DIM_RESET;
      dim_z_q <= DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DIM_X: dim_x_q <= cfg_data_i;
        CFG_DIM_Y: dim_y_q <= cfg_data_i;
        CFG_DIM_Z: dim_z_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign in_ready_o = !q_full;
  assign q_push     = in_valid_i && !q_full;

  rbvf_front #(
    .MaxDimX (MAX_DIM_X),
    .MaxDimY (MAX_DIM_Y),
    .MaxDimZ (MAX_DIM_Z),
    .ZyW     (ZyW)
  ) u_front (
    .dim_x_i (dim_x_q),
    .dim_y_i (dim_y_q),
    .dim_z_i (dim_z_q),
    .req_i   (in_req_i),
    .cmd_o   (front_cmd),
    .zy_o    (front_zy)
  );

  rbvf_queue #(
    .ZyW (ZyW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (front_cmd),
    .zy_i    (front_zy),
    .pop_i   (q_pop),
    .cmd_o   (head_cmd),
    .zy_o    (head_zy),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  rbvf_back #(
    .MaxDimX (MAX_DIM_X),
    .MaxDimY (MAX_DIM_Y),
    .MaxDimZ (MAX_DIM_Z),
    .ZyW     (ZyW),
    .AddrW   (AddrW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .zy_i        (head_zy),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

@@ tb/rim_border_voxel_filter_tb.sv @@
// Self-checking testbench for the border voxel filter: random label volumes, queries and dims.
`timescale 1ns / 1ps

module rim_border_voxel_filter_tb;
  import rbvf_pkg::*;

  localparam int unsigned MAX_DIM    = 64;
  localparam int unsigned VOX_N      = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int unsigned ITEMS      = 1900;
  localparam int unsigned BOX        = 5;
  localparam int unsigned SETTLE_CYC = 32;
  localparam int unsigned HOLD_CYC   = 300;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  in_req_t            in_req_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_rsp_t           out_rsp_o;
  logic               cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]   cfg_data_i = '0;

  class label_checker;
    logic [LABEL_W-1:0] vox_mem [VOX_N];
    int unsigned nx, ny, nz;
    out_rsp_t filtered_q[$];
    int unsigned fail_cnt;

    function new();
      nx = MAX_DIM;
      ny = MAX_DIM;
      nz = MAX_DIM;
      fail_cnt = 0;
      foreach (vox_mem[i]) vox_mem[i] = LABEL_NONE;
    endfunction

    function int unsigned cell_of(int x, int y, int z);
      return (z * MAX_DIM + y) * MAX_DIM + x;
    endfunction

    function int unsigned eff_dim(logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
    endfunction

    function void set_dim(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
      case (idx)
        CFG_DIM_X: nx = eff_dim(v);
        CFG_DIM_Y: ny = eff_dim(v);
        CFG_DIM_Z: nz = eff_dim(v);
        default: ;
      endcase
    endfunction

    function bit ribbon_at(int x, int y, int z);
      return vox_mem[cell_of(x, y, z)] == LABEL_RIBBON;
    endfunction

    function void take_request(in_req_t r);
      out_rsp_t want;
      logic [LABEL_W-1:0] cur;
      int x, y, z;
      bit in_vol, near_ribbon;
      x = r.pos_x;
      y = r.pos_y;
      z = r.pos_z;
      in_vol = (x < nx) && (y < ny) && (z < nz);
      if (r.func == FUNC_WRITE) begin
        if (in_vol) vox_mem[cell_of(x, y, z)] = r.label_in;
        return;
      end
      want.label_out = LABEL_NONE;
      want.removed = 1'b0;
      if (in_vol) begin
        cur = vox_mem[cell_of(x, y, z)];
        want.label_out = cur;
        if (cur == LABEL_CSF || cur == LABEL_WM) begin
          near_ribbon = (x > 0 && ribbon_at(x - 1, y, z)) ||
                        (x + 1 < nx && ribbon_at(x + 1, y, z)) ||
                        (y > 0 && ribbon_at(x, y - 1, z)) ||
                        (y + 1 < ny && ribbon_at(x, y + 1, z)) ||
                        (z > 0 && ribbon_at(x, y, z - 1)) ||
                        (z + 1 < nz && ribbon_at(x, y, z + 1));
          if (!near_ribbon) begin
            want.label_out = LABEL_NONE;
            want.removed = 1'b1;
          end
        end
      end
      filtered_q.push_back(want);
    endfunction

    function void check_response(out_rsp_t got);
      out_rsp_t want;
      if (filtered_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("response with no request pending: label %0d removed %0b",
                   got.label_out, got.removed);
        return;
      end
      want = filtered_q.pop_front();
      if (got.label_out !== want.label_out || got.removed !== want.removed) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("mismatch: expected label %0d removed %0b, got label %0d removed %0b",
                   want.label_out, want.removed, got.label_out, got.removed);
      end
    endfunction

    function int unsigned pending();
      return filtered_q.size();
    endfunction
  endclass

  label_checker sb = new();
  bit written_map [VOX_N];
  int unsigned tx_idle_pct = 13;
  int unsigned rx_idle_pct = 78;
  int unsigned item_cnt = 0;
  int unsigned phase_cnt = 0;
  int unsigned hold_token = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  rim_border_voxel_filter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYC;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.take_request(in_req_i);
      if (out_valid_o && out_ready_i) sb.check_response(out_rsp_o);
    end
  end

  initial begin
    #5_000_000;
    $display("rim_border_voxel_filter_tb failed");
    $finish;
  end

  // A voxel may be queried only when it and every neighbor inside the volume hold a label.
  function automatic bit query_safe(int x, int y, int z);
    return written_map[sb.cell_of(x, y, z)] &&
           (x == 0 || written_map[sb.cell_of(x - 1, y, z)]) &&
           (x + 1 >= sb.nx || written_map[sb.cell_of(x + 1, y, z)]) &&
           (y == 0 || written_map[sb.cell_of(x, y - 1, z)]) &&
           (y + 1 >= sb.ny || written_map[sb.cell_of(x, y + 1, z)]) &&
           (z == 0 || written_map[sb.cell_of(x, y, z - 1)]) &&
           (z + 1 >= sb.nz || written_map[sb.cell_of(x, y, z + 1)]);
  endfunction

  function automatic logic [LABEL_W-1:0] pick_label();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return LABEL_RIBBON;
    if (r < 50) return LABEL_CSF;
    if (r < 70) return LABEL_WM;
    if (r < 80) return LABEL_NONE;
    return LABEL_W'($urandom_range(0, 15));
  endfunction

  function automatic logic [CFG_W-1:0] extreme_dim();
    case ($urandom_range(0, 3))
      0: return CFG_W'(0);
      1: return CFG_W'(1);
      2: return DIM_RESET;
      default: return CFG_W'($urandom_range(65, 127));
    endcase
  endfunction

  task automatic send_item(input logic f, input int x, input int y, input int z,
                           input logic [LABEL_W-1:0] lab);
    in_req_t r;
    r.func = f;
    r.pos_x = POS_W'(x);
    r.pos_y = POS_W'(y);
    r.pos_z = POS_W'(z);
    r.label_in = lab;
    if (f == FUNC_WRITE && x < sb.nx && y < sb.ny && z < sb.nz)
      written_map[sb.cell_of(x, y, z)] = 1'b1;
    in_valid_i <= 1'b1;
    in_req_i <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    item_cnt++;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic settle();
    wait_results_done();
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_dims(input logic [CFG_W-1:0] dx, input logic [CFG_W-1:0] dy,
                            input logic [CFG_W-1:0] dz);
    logic [CFG_W-1:0] junk;
    junk = CFG_W'($urandom_range(0, 127));
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_DIM_X;
    cfg_data_i <= dx;
    sb.set_dim(CFG_DIM_X, dx);
    @(posedge clk_i);
    cfg_idx_i <= CFG_DIM_Y;
    cfg_data_i <= dy;
    sb.set_dim(CFG_DIM_Y, dy);
    @(posedge clk_i);
    cfg_idx_i <= CFG_DIM_Z;
    cfg_data_i <= dz;
    sb.set_dim(CFG_DIM_Z, dz);
    @(posedge clk_i);
    cfg_idx_i <= CFG_UNUSED;
    cfg_data_i <= junk;
    sb.set_dim(CFG_UNUSED, junk);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic pick_outside(output int x, output int y, output int z);
    int axis;
    x = $urandom_range(0, 63);
    y = $urandom_range(0, 63);
    z = $urandom_range(0, 63);
    do axis = $urandom_range(0, 2);
    while ((axis == 0 && sb.nx >= MAX_DIM) || (axis == 1 && sb.ny >= MAX_DIM) ||
           (axis == 2 && sb.nz >= MAX_DIM));
    case (axis)
      0: x = $urandom_range(sb.nx, 63);
      1: y = $urandom_range(sb.ny, 63);
      default: z = $urandom_range(sb.nz, 63);
    endcase
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] dx, input logic [CFG_W-1:0] dy,
                           input logic [CFG_W-1:0] dz, input bit hi_corner, input int n_ops);
    int sx, sy, sz, ox, oy, oz, x, y, z, kind;
    bit found, can_leave;
    settle();
    write_dims(dx, dy, dz);
    sx = (sb.nx < BOX) ? sb.nx : BOX;
    sy = (sb.ny < BOX) ? sb.ny : BOX;
    sz = (sb.nz < BOX) ? sb.nz : BOX;
    ox = hi_corner ? sb.nx - sx : 0;
    oy = hi_corner ? sb.ny - sy : 0;
    oz = hi_corner ? sb.nz - sz : 0;
    can_leave = (sb.nx < MAX_DIM) || (sb.ny < MAX_DIM) || (sb.nz < MAX_DIM);
    for (int k = 0; k < sz; k++)
      for (int j = 0; j < sy; j++)
        for (int i = 0; i < sx; i++)
          send_item(FUNC_WRITE, ox + i, oy + j, oz + k, pick_label());
    for (int n = 0; n < n_ops; n++) begin
      if (phase_cnt == 2 && n == 0) hold_token++;
      if (phase_cnt == 4 && n == n_ops / 2) wait_results_done();
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        found = 1'b0;
        for (int t = 0; t < 30 && !found; t++) begin
          x = ox + $urandom_range(0, sx - 1);
          y = oy + $urandom_range(0, sy - 1);
          z = oz + $urandom_range(0, sz - 1);
          found = query_safe(x, y, z);
        end
        if (found) send_item(FUNC_QUERY, x, y, z, LABEL_W'($urandom_range(0, 15)));
        else kind = 85;
      end
      if (kind >= 85 && !can_leave) kind = 70;
      if (kind >= 60 && kind < 85) begin
        send_item(FUNC_WRITE, ox + $urandom_range(0, sx - 1), oy + $urandom_range(0, sy - 1),
                  oz + $urandom_range(0, sz - 1), pick_label());
      end else if (kind >= 85) begin
        pick_outside(x, y, z);
        send_item((kind < 93) ? FUNC_QUERY : FUNC_WRITE, x, y, z,
                  LABEL_W'($urandom_range(0, 15)));
      end
    end
    phase_cnt++;
  endtask

  initial begin
    logic [CFG_W-1:0] dx, dy, dz;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A row of three voxels: border labels kept and cleared, ribbon and other labels passed.
    write_dims(CFG_W'(3), CFG_W'(1), CFG_W'(1));
    send_item(FUNC_WRITE, 0, 0, 0, LABEL_CSF);
    send_item(FUNC_WRITE, 1, 0, 0, LABEL_RIBBON);
    send_item(FUNC_WRITE, 2, 0, 0, LABEL_WM);
    send_item(FUNC_QUERY, 0, 0, 0, LABEL_NONE);
    send_item(FUNC_QUERY, 1, 0, 0, LABEL_NONE);
    send_item(FUNC_QUERY, 2, 0, 0, LABEL_NONE);
    send_item(FUNC_WRITE, 1, 0, 0, LABEL_W'(15));
    send_item(FUNC_QUERY, 0, 0, 0, LABEL_NONE);
    send_item(FUNC_QUERY, 2, 0, 0, LABEL_NONE);
    send_item(FUNC_QUERY, 1, 0, 0, LABEL_NONE);
    send_item(FUNC_WRITE, 63, 63, 63, LABEL_RIBBON);
    send_item(FUNC_QUERY, 63, 63, 63, LABEL_W'(15));
    send_item(FUNC_QUERY, 3, 0, 0, LABEL_NONE);
    send_item(FUNC_WRITE, 1, 0, 0, LABEL_NONE);
    send_item(FUNC_QUERY, 1, 0, 0, LABEL_NONE);
    send_item(FUNC_QUERY, 0, 0, 0, LABEL_NONE);

    // Zero counts as one and oversize values clamp to the maximum.
    settle();
    write_dims(CFG_W'(0), CFG_W'(127), CFG_W'(0));
    send_item(FUNC_WRITE, 0, 1, 0, LABEL_RIBBON);
    send_item(FUNC_QUERY, 0, 0, 0, LABEL_NONE);
    send_item(FUNC_QUERY, 0, 1, 0, LABEL_NONE);

    run_phase(CFG_W'(127), DIM_RESET, CFG_W'(100), 1'b1, 40);
    while (item_cnt < ITEMS) begin
      if (item_cnt < ITEMS / 3) begin
        tx_idle_pct = 13;
        rx_idle_pct = 78;
      end else if (item_cnt < 2 * ITEMS / 3) begin
        tx_idle_pct = 78;
        rx_idle_pct = 13;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if ($urandom_range(0, 9) == 0) begin
        dx = extreme_dim();
        dy = extreme_dim();
        dz = extreme_dim();
      end else begin
        dx = CFG_W'($urandom_range(1, BOX));
        dy = CFG_W'($urandom_range(1, BOX));
        dz = CFG_W'($urandom_range(1, BOX));
      end
      run_phase(dx, dy, dz, $urandom_range(0, 1), 40);
    end

    settle();
    if (sb.fail_cnt == 0 && sb.pending() == 0) begin
      $display("rim_border_voxel_filter_tb passed");
    end else begin
      $display("rim_border_voxel_filter_tb failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/rbvf_pkg.sv
sv/rbvf_front.sv
sv/rbvf_queue.sv
sv/rbvf_back.sv
sv/rim_border_voxel_filter.sv
tb/rim_border_voxel_filter_tb.sv
